@@ src/stfir_pkg.sv @@
// ----------------------------------------------------------------------------
// stfir_pkg
// Shared constants and controller/datapath interface types for the stereo
// FIR left-channel block.
// ----------------------------------------------------------------------------
package stfir_pkg;

  localparam int COEF_BITS  = 16;
  localparam int GAIN_BITS  = 16;
  localparam int ACC_BITS   = 41;
  // The saturated accumulator is split in two parts for the gain multiply.
  localparam int LO_W       = 25;
  localparam int HI_W       = ACC_BITS - LO_W;
  localparam int FULL_W     = ACC_BITS + GAIN_BITS + 1;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd18350;

  // Item kinds.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Register select, taken from paddr[2].
  localparam logic REG_FILTER_ENABLE = 1'b0;
  localparam logic REG_OUTPUT_GAIN   = 1'b1;

  typedef struct packed {
    logic coef_we;    // write coefficient from the input ports
    logic capture;    // latch the input samples
    logic hist_wr;    // store sample into history, start tap sweep
    logic mac_issue;  // read one tap pair and advance
    logic sat_ld;     // saturate accumulator
    logic glo_ld;     // low partial product with gain
    logic ghi_ld;     // high partial product with gain
    logic sum_ld;     // combine partial products
    logic out_ld;     // load the output register
    logic out_filt;   // output register takes the filtered value
  } dp_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
  } dp_sts_t;

endpackage

@@ src/stfir_dp.sv @@
// ----------------------------------------------------------------------------
// stfir_dp
// Datapath: history and coefficient memories, MAC pipeline, gain scaling,
// saturation and output register.
// ----------------------------------------------------------------------------
module stfir_dp #(
  parameter int NUM_TAPS    = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stfir_pkg::dp_cmd_t              cmd_i,
  output stfir_pkg::dp_sts_t              sts_o,
  input  logic signed [SAMPLE_BITS-1:0]   left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]   right_in_i,
  input  logic [8:0]                      coef_index_i,
  input  logic signed [stfir_pkg::COEF_BITS-1:0] coef_value_i,
  input  logic [stfir_pkg::GAIN_BITS-1:0] gain_i,
  output logic signed [SAMPLE_BITS-1:0]   left_out_o,
  output logic signed [SAMPLE_BITS-1:0]   right_out_o
);
  import stfir_pkg::*;

  localparam int TAP_W  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
  localparam int FILL_W = $clog2(NUM_TAPS + 1);
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + TAP_W + 1;
  localparam int PHI_W  = HI_W + GAIN_BITS + 1;
  localparam int PLO_W  = LO_W + GAIN_BITS;
  localparam int SHIFT  = SAMPLE_BITS - 1 + GAIN_BITS;
  localparam int YW     = FULL_W - SHIFT;
  localparam int YX_W   = (YW > SAMPLE_BITS) ? YW : SAMPLE_BITS;
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(NUM_TAPS - 1);

  logic signed [COEF_BITS-1:0]   coef_mem [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [NUM_TAPS];

  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic [TAP_W-1:0]              p_q, p_d, k_q, k_d, idx_q, idx_d;
  logic [FILL_W-1:0]             fill_q, fill_d;
  logic                          v1_q, v2_q, hv1_q;
  logic signed [COEF_BITS-1:0]   coef_rd_q;
  logic signed [SAMPLE_BITS-1:0] hist_rd_q, hist_sel;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [ACC_BITS-1:0]    accs_q, accs_d;
  logic [ACC_W-ACC_BITS:0]       acc_top;
  logic [LO_W-1:0]               acc_lo;
  logic signed [HI_W-1:0]        acc_hi;
  logic [PLO_W-1:0]              plo_q;
  logic signed [PHI_W-1:0]       phi_q;
  logic signed [FULL_W-1:0]      full_q;
  logic signed [YW-1:0]          y_v;
  logic signed [YX_W-1:0]        yx_v;
  logic [YX_W-SAMPLE_BITS:0]     y_top;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [SAMPLE_BITS-1:0] left_out_q, left_out_d, right_out_q;
  logic                          coef_ok;
  logic [TAP_W-1:0]              coef_addr;

  assign coef_ok   = 32'(coef_index_i) < NUM_TAPS;
  assign coef_addr = TAP_W'(coef_index_i);

  // Coefficient memory: written by coefficient items, read by the tap sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we && coef_ok) begin
      coef_mem[coef_addr] <= coef_value_i;
    end
    if (cmd_i.mac_issue) begin
      coef_rd_q <= coef_mem[k_q];
    end
  end

  // History memory. Entries at or beyond the fill count were never written
  // since reset and read as zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr) begin
      hist_mem[p_q] <= left_q;
    end
    if (cmd_i.mac_issue) begin
      hist_rd_q <= hist_mem[idx_q];
      hv1_q     <= FILL_W'(idx_q) < fill_q;
    end
  end

  always_comb begin
    p_d    = p_q;
    fill_d = fill_q;
    k_d    = k_q;
    idx_d  = idx_q;
    if (cmd_i.hist_wr) begin
      p_d   = (p_q == LAST_TAP) ? '0 : p_q + 1'b1;
      k_d   = '0;
      idx_d = p_q;
      if (fill_q != FILL_W'(NUM_TAPS)) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (cmd_i.mac_issue) begin
      k_d   = k_q + 1'b1;
      idx_d = (idx_q == '0) ? LAST_TAP : idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      fill_q <= '0;
      k_q    <= '0;
      idx_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      p_q    <= p_d;
      fill_q <= fill_d;
      k_q    <= k_d;
      idx_q  <= idx_d;
      v1_q   <= cmd_i.mac_issue;
      v2_q   <= v1_q;
    end
  end

  assign hist_sel = hv1_q ? hist_rd_q : '0;

  // Saturate the exact sum to the 41-bit accumulator range.
  assign acc_top = acc_q[ACC_W-1:ACC_BITS-1];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      accs_d = acc_q[ACC_BITS-1:0];
    end else if (acc_q[ACC_W-1]) begin
      accs_d = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      accs_d = {1'b0, {(ACC_BITS-1){1'b1}}};
    end
  end

  assign acc_lo = accs_q[LO_W-1:0];
  assign acc_hi = accs_q[ACC_BITS-1:LO_W];

  // Arithmetic shift right gives the floor of the scaled value.
  assign y_v   = YW'(full_q >>> SHIFT);
  assign yx_v  = YX_W'(y_v);
  assign y_top = yx_v[YX_W-1:SAMPLE_BITS-1];
  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_sat = yx_v[SAMPLE_BITS-1:0];
    end else if (yx_v[YX_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign left_out_d = cmd_i.out_filt ? y_sat : left_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      left_q  <= left_in_i;
      right_q <= right_in_i;
    end
    if (v1_q) begin
      prod_q <= coef_rd_q * hist_sel;
    end
    if (cmd_i.hist_wr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.sat_ld) begin
      accs_q <= accs_d;
    end
    if (cmd_i.glo_ld) begin
      plo_q <= acc_lo * gain_i;
    end
    if (cmd_i.ghi_ld) begin
      phi_q <= acc_hi * $signed({1'b0, gain_i});
    end
    if (cmd_i.sum_ld) begin
      full_q <= (FULL_W'(phi_q) <<< LO_W) + FULL_W'(plo_q);
    end
    if (cmd_i.out_ld) begin
      left_out_q  <= left_out_d;
      right_out_q <= right_q;
    end
  end

  assign sts_o.last_tap  = (k_q == LAST_TAP);
  assign sts_o.pipe_busy = v1_q | v2_q;

  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

@@ src/stfir_ctrl.sv @@
// ----------------------------------------------------------------------------
// stfir_ctrl
// Controller: accepts items, sequences the tap sweep and the scaling steps,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module stfir_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic               filter_enable_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  stfir_pkg::dp_sts_t sts_i,
  output stfir_pkg::dp_cmd_t cmd_o
);
  import stfir_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HWR   = 9'b000000010,
    S_MAC   = 9'b000000100,
    S_DRAIN = 9'b000001000,
    S_SAT   = 9'b000010000,
    S_GLO   = 9'b000100000,
    S_GHI   = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_RES   = 9'b100000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        filt_q, filt_d;
  logic        out_valid_q, out_valid_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    filt_d  = filt_q;
    cmd_o   = '0;
    cmd_o.out_filt = filt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (operation_i == OP_COEF) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            filt_d  = filter_enable_i;
            state_d = filter_enable_i ? S_HWR : S_RES;
          end
        end
      end
      S_HWR: begin
        cmd_o.hist_wr = 1'b1;
        state_d       = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.last_tap) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The accumulator holds the full sum once the read and product
        // stages are empty.
        if (!sts_i.pipe_busy) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        cmd_o.sat_ld = 1'b1;
        state_d      = S_GLO;
      end
      S_GLO: begin
        cmd_o.glo_ld = 1'b1;
        state_d      = S_GHI;
      end
      S_GHI: begin
        cmd_o.ghi_ld = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_ld = 1'b1;
        state_d      = S_RES;
      end
      S_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filt_q      <= filt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/stereo_fir_left_channel.sv @@
// ----------------------------------------------------------------------------
// stereo_fir_left_channel: left-channel FIR with gain, right passes through.
// Filtered sample: one tap MAC a cycle over the single-port coefficient and
// history memories, then saturation and gain scaling; one item at a time.
// Pass-through sample: output register only. Coefficient item: no result.
// Reset clears control, history fill and pointer; coefficients stay unknown.
// ----------------------------------------------------------------------------
module stereo_fir_left_channel #(
  parameter int NUM_TAPS    = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic [8:0]                    coef_index_i,
  input  logic signed [stfir_pkg::COEF_BITS-1:0] coef_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import stfir_pkg::*;

  logic                 enable_q, enable_d;
  logic [GAIN_BITS-1:0] gain_q, gain_d;
  logic                 cfg_wr;
  dp_cmd_t              cmd;
  dp_sts_t              sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    enable_d = enable_q;
    gain_d   = gain_q;
    if (cfg_wr) begin
      if (paddr[2] == REG_FILTER_ENABLE) begin
        enable_d = pwdata[0];
      end else begin
        gain_d = pwdata[GAIN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      gain_q   <= GAIN_RESET;
    end else begin
      enable_q <= enable_d;
      gain_q   <= gain_d;
    end
  end

  assign prdata = (paddr[2] == REG_OUTPUT_GAIN) ? {16'b0, gain_q} : {31'b0, enable_q};

  stfir_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .filter_enable_i (enable_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  stfir_dp #(
    .NUM_TAPS    (NUM_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .gain_i       (gain_q),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o)
  );

endmodule
